// File: rtl/core/adtr_pkg.sv
package adtr_pkg;

   localparam int ADC_BITS_DEFAULT = 10;
   localparam int DIGITS_DEFAULT   = 4;

   localparam int CNT_W   = 16;
   localparam int ZO_W    = 10;
   localparam int SLOPE_W = 16;
   localparam int DP_W    = 3;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic [CNT_W-1:0]   SAMPLE_COUNT_RESET     = 16'd1000;
   localparam logic [ZO_W-1:0]    ZERO_OFFSET_RESET      = 10'd544;
   localparam logic [SLOPE_W-1:0] SLOPE_Q8_RESET         = 16'hFB00;
   localparam logic [DP_W-1:0]    DECIMAL_POSITION_RESET = 3'd3;

   localparam logic [1:0] REG_SAMPLE_COUNT     = 2'd0;
   localparam logic [1:0] REG_ZERO_OFFSET      = 2'd1;
   localparam logic [1:0] REG_SLOPE_Q8         = 2'd2;
   localparam logic [1:0] REG_DECIMAL_POSITION = 2'd3;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;

   typedef struct packed {
      logic [CNT_W-1:0]          sample_count;
      logic [ZO_W-1:0]           zero_offset;
      logic signed [SLOPE_W-1:0] slope_q8;
      logic [DP_W-1:0]           decimal_position;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_N,
      ST_SUB,
      ST_MUL_S,
      ST_DIV,
      ST_SAT,
      ST_BCD,
      ST_EMIT
   } state_type;

   function automatic int pow10(input int digits);
      int p;
      p = 1;
      for (int i = 0; i < digits; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

endpackage

// File: rtl/core/adtr_csr.sv
module adtr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [adtr_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [adtr_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [adtr_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output adtr_pkg::cfg_type             cfg
);
   import adtr_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] index;
   logic       write;

   assign index      = csr_paddr[CSR_AW-1:2];
   assign write      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (index)
            REG_SAMPLE_COUNT:     cfg_in.sample_count     = csr_pwdata[CNT_W-1:0];
            REG_ZERO_OFFSET:      cfg_in.zero_offset      = csr_pwdata[ZO_W-1:0];
            REG_SLOPE_Q8:         cfg_in.slope_q8         = csr_pwdata[SLOPE_W-1:0];
            REG_DECIMAL_POSITION: cfg_in.decimal_position = csr_pwdata[DP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SAMPLE_COUNT:     csr_prdata = CSR_DW'(cfg_ff.sample_count);
         REG_ZERO_OFFSET:      csr_prdata = CSR_DW'(cfg_ff.zero_offset);
         REG_SLOPE_Q8:         csr_prdata = CSR_DW'(unsigned'(cfg_ff.slope_q8));
         REG_DECIMAL_POSITION: csr_prdata = CSR_DW'(cfg_ff.decimal_position);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_count     <= SAMPLE_COUNT_RESET;
         cfg_ff.zero_offset      <= ZERO_OFFSET_RESET;
         cfg_ff.slope_q8         <= SLOPE_Q8_RESET;
         cfg_ff.decimal_position <= DECIMAL_POSITION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/averaged_adc_temperature_readout_unit.sv
// Sums ADC samples over a window of sample_count samples and, when a window
// closes, emits the temperature in tenths of a degree as DIGITS ASCII digits,
// most significant first, with an optional '.' and tlast on the final digit.
// A sample that does not close a window is only added to the running sum, so
// samples may stream at one per cycle. The sample that closes a window starts a
// bit-serial computation through the shift-add multiplier run twice, the
// restoring divider that takes one quotient bit per cycle and the binary to BCD
// converter that takes one bit per cycle. The characters then leave at one per
// cycle while the result side is ready, and the next sample is taken once the
// last character sits in the output register.
module averaged_adc_temperature_readout_unit #(
   parameter int ADC_BITS = adtr_pkg::ADC_BITS_DEFAULT,
   parameter int DIGITS   = adtr_pkg::DIGITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata fields from bit 0: adc_sample
   input  logic [8*((ADC_BITS+7)/8)-1:0]  req_tdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // rsp_tdata fields from bit 0: ascii_char
   output logic [7:0]                     rsp_tdata,
   output logic                           rsp_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [adtr_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [adtr_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [adtr_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                           csr_pready
);
   import adtr_pkg::*;

   localparam int SW    = ADC_BITS + CNT_W;
   localparam int PW    = SW + SLOPE_W;
   localparam int LIMIT = pow10(DIGITS) - 1;
   localparam int VW    = $clog2(LIMIT + 1);
   localparam int BW    = 4 * DIGITS;
   localparam int CTW   = $clog2(PW);
   localparam int DIW   = $clog2(DIGITS);

   cfg_type cfg;

   adtr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   state_type            state_ff, state_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]     taken_ff, taken_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [SW-1:0]        wsum_ff, wsum_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic [SW-1:0]        mcand_ff, mcand_in;
   logic [CNT_W-1:0]     mplier_ff, mplier_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic                 neg_ff, neg_in;
   logic [CTW-1:0]       cnt_ff, cnt_in;
   logic [VW-1:0]        val_ff, val_in;
   logic [BW-1:0]        bcd_ff, bcd_in;
   logic [DIW-1:0]       di_ff, di_in;
   logic                 dot_ff, dot_in;
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_char_ff, out_char_in;
   logic                 out_last_ff, out_last_in;

   logic [ADC_BITS-1:0]  sample;
   logic [SW-1:0]        sum_next;
   logic [CNT_W-1:0]     n_next;
   logic [CNT_W-1:0]     target;
   logic [PW-1:0]        acc_shift_add;
   logic [SW:0]          diff;
   logic [SW-1:0]        mag;
   logic [SLOPE_W-1:0]   slope_mag;
   logic [CNT_W:0]       rem_trial;
   logic                 rem_ge;
   logic [CNT_W:0]       rem_sub;
   logic [PW-9:0]        quotient;
   logic [BW-1:0]        bcd_adj;

   assign sample     = req_tdata[ADC_BITS-1:0];
   assign sum_next   = sum_ff + SW'(sample);
   assign n_next     = taken_ff + CNT_W'(1);
   assign target     = (cfg.sample_count == '0) ? CNT_W'(1) : cfg.sample_count;
   assign req_tready = (state_ff == ST_IDLE);

   assign acc_shift_add = {acc_ff[PW-2:0], 1'b0}
                        + (mplier_ff[CNT_W-1] ? PW'(mcand_ff) : '0);
   assign diff      = {1'b0, acc_ff[SW-1:0]} - {1'b0, wsum_ff};
   assign mag       = diff[SW] ? (~diff[SW-1:0] + SW'(1)) : diff[SW-1:0];
   assign slope_mag = cfg.slope_q8[SLOPE_W-1] ? (~cfg.slope_q8 + SLOPE_W'(1))
                                              : cfg.slope_q8;
   assign rem_trial = {rem_ff, acc_ff[PW-1]};
   assign rem_ge    = (rem_trial >= {1'b0, n_ff});
   assign rem_sub   = rem_trial - {1'b0, n_ff};
   assign quotient  = acc_ff[PW-1:8];

   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? (bcd_ff[4*d +: 4] + 4'd3)
                                                         : bcd_ff[4*d +: 4];
      end
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      taken_in     = taken_ff;
      n_in         = n_ff;
      wsum_in      = wsum_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      val_in       = val_ff;
      bcd_in       = bcd_ff;
      di_in        = di_ff;
      dot_in       = dot_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (n_next >= target) begin
                  wsum_in   = sum_next;
                  n_in      = n_next;
                  sum_in    = '0;
                  taken_in  = '0;
                  mcand_in  = SW'(cfg.zero_offset);
                  mplier_in = n_next;
                  acc_in    = '0;
                  cnt_in    = '0;
                  state_in  = ST_MUL_N;
               end else begin
                  sum_in   = sum_next;
                  taken_in = n_next;
               end
            end
         end
         ST_MUL_N: begin
            acc_in    = acc_shift_add;
            mplier_in = {mplier_ff[CNT_W-2:0], 1'b0};
            cnt_in    = cnt_ff + CTW'(1);
            if (cnt_ff == CTW'(CNT_W - 1)) begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            neg_in    = diff[SW] ^ cfg.slope_q8[SLOPE_W-1];
            mcand_in  = mag;
            mplier_in = slope_mag;
            acc_in    = '0;
            cnt_in    = '0;
            state_in  = ST_MUL_S;
         end
         ST_MUL_S: begin
            acc_in    = acc_shift_add;
            mplier_in = {mplier_ff[CNT_W-2:0], 1'b0};
            cnt_in    = cnt_ff + CTW'(1);
            if (cnt_ff == CTW'(SLOPE_W - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_sub[CNT_W-1:0] : rem_trial[CNT_W-1:0];
            acc_in = {acc_ff[PW-2:0], rem_ge};
            cnt_in = cnt_ff + CTW'(1);
            if (cnt_ff == CTW'(PW - 1)) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (neg_ff) begin
               val_in = '0;
            end else if (quotient > (PW-8)'(LIMIT)) begin
               val_in = VW'(LIMIT);
            end else begin
               val_in = quotient[VW-1:0];
            end
            bcd_in   = '0;
            cnt_in   = '0;
            state_in = ST_BCD;
         end
         ST_BCD: begin
            bcd_in = {bcd_adj[BW-2:0], val_ff[VW-1]};
            val_in = {val_ff[VW-2:0], 1'b0};
            cnt_in = cnt_ff + CTW'(1);
            if (cnt_ff == CTW'(VW - 1)) begin
               di_in    = '0;
               dot_in   = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               if ((DP_W'(di_ff) == cfg.decimal_position) && !dot_ff) begin
                  out_char_in = CHAR_DOT;
                  out_last_in = 1'b0;
                  dot_in      = 1'b1;
               end else begin
                  out_char_in = CHAR_ZERO + {4'd0, bcd_ff[BW-1 -: 4]};
                  out_last_in = (di_ff == DIW'(DIGITS - 1));
                  bcd_in      = {bcd_ff[BW-5:0], 4'd0};
                  di_in       = di_ff + DIW'(1);
                  dot_in      = 1'b0;
                  if (di_ff == DIW'(DIGITS - 1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         taken_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         taken_ff     <= taken_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      wsum_ff     <= wsum_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      val_ff      <= val_in;
      bcd_ff      <= bcd_in;
      di_ff       <= di_in;
      dot_ff      <= dot_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import adtr_pkg::*;

   localparam int ADC_BITS = ADC_BITS_DEFAULT;
   localparam int DIGITS   = DIGITS_DEFAULT;
   localparam int SETTLE   = 100;
   localparam int HOLD_LEN = 300;

   typedef struct packed {
      logic        is_cfg;
      logic [1:0]  idx;
      logic [31:0] value;
      logic [39:0] text;
   } plan_row_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic [15:0]         req_tdata   = '0;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [7:0]          rsp_tdata;
   logic                rsp_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // Predictor copy of the registers and of the running window.
   logic [CNT_W-1:0]          cfg_count;
   logic [ZO_W-1:0]           cfg_zo;
   logic signed [SLOPE_W-1:0] cfg_slope;
   logic [DP_W-1:0]           cfg_dp;
   logic [ADC_BITS+15:0]      win_sum;
   logic [15:0]               win_taken;

   logic [8:0]    expected_chars[$];
   plan_row_type  plan[$];
   int          mismatches     = 0;
   int          samples_sent   = 0;
   int          readings_due   = 0;
   int          chars_seen     = 0;
   int          settings_used  = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   bit          long_hold      = 1'b0;
   bit          realistic      = 1'b0;

   averaged_adc_temperature_readout_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH at %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic logic [31:0] reg_mask(input logic [1:0] idx);
      case (idx)
         REG_SAMPLE_COUNT: reg_mask = (32'd1 << CNT_W) - 1;
         REG_ZERO_OFFSET:  reg_mask = (32'd1 << ZO_W) - 1;
         REG_SLOPE_Q8:     reg_mask = (32'd1 << SLOPE_W) - 1;
         default:          reg_mask = (32'd1 << DP_W) - 1;
      endcase
   endfunction

   // Adds a sample; when the window closes, queues the reading's characters.
   task automatic predict_reading(input logic [15:0] data);
      longint n, target, num, q, lim, v;
      int     bcd[DIGITS];
      int     i;
      target = (cfg_count == 0) ? 1 : longint'(cfg_count);
      win_sum = win_sum + data[ADC_BITS-1:0];
      n = longint'(win_taken) + 1;
      if (n < target) begin
         win_taken = 16'(n);
         return;
      end
      num = longint'(cfg_zo) * n - longint'(win_sum);
      q = (num * longint'(cfg_slope)) / (n * 256);
      lim = 1;
      for (i = 0; i < DIGITS; i++) lim = lim * 10;
      lim = lim - 1;
      v = (q < 0) ? 0 : (q > lim) ? lim : q;
      win_sum = '0;
      win_taken = '0;
      for (i = DIGITS - 1; i >= 0; i--) begin
         bcd[i] = int'(v % 10);
         v = v / 10;
      end
      for (i = 0; i < DIGITS; i++) begin
         if (i == int'(cfg_dp)) expected_chars.push_back({1'b0, CHAR_DOT});
         expected_chars.push_back({(i == DIGITS - 1), CHAR_ZERO + 8'(bcd[i])});
      end
      readings_due++;
   endtask

   always @(posedge clock) begin
      logic [8:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         chars_seen++;
         if (expected_chars.size() == 0) begin
            report_mismatch("character with no reading pending", rsp_tdata, 0);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata !== want[7:0]) report_mismatch("ascii_char", rsp_tdata, want[7:0]);
            if (rsp_tlast !== want[8]) report_mismatch("last_char", rsp_tlast, want[8]);
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
            long_hold = 1'b0;
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // All bus tasks start and end just after a falling edge.
   task automatic csr_read(input logic [1:0] idx, output logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] rd;
      logic [31:0] v;
      v = value & reg_mask(idx);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_SAMPLE_COUNT: cfg_count = v[CNT_W-1:0];
         REG_ZERO_OFFSET:  cfg_zo    = v[ZO_W-1:0];
         REG_SLOPE_Q8:     cfg_slope = v[SLOPE_W-1:0];
         default:          cfg_dp    = v[DP_W-1:0];
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_read(idx, rd);
      if ((rd & reg_mask(idx)) !== v) report_mismatch("register read back", rd, v);
   endtask

   task automatic send_sample(input logic [15:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_reading(data);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic pick_setting();
      int pick;
      logic [15:0] cnt;
      logic [15:0] slope;
      logic [9:0]  zo;
      pick = $urandom_range(0, 9);
      if (pick == 0) cnt = 16'd0;
      else if (pick < 7) cnt = 16'($urandom_range(1, 6));
      else cnt = 16'($urandom_range(7, 30));
      realistic = ($urandom_range(0, 1) == 1);
      if (realistic) begin
         zo    = 10'($urandom_range(400, 700));
         slope = 16'(-$urandom_range(256, 3000));
      end else begin
         pick = $urandom_range(0, 5);
         zo    = (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023 : 10'($urandom_range(0, 1023));
         pick = $urandom_range(0, 5);
         slope = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF :
                 16'($urandom_range(0, 65535));
      end
      csr_write(REG_SAMPLE_COUNT, {16'($urandom_range(0, 65535)), cnt});
      csr_write(REG_ZERO_OFFSET, {22'($urandom_range(0, 4194303)), zo});
      csr_write(REG_SLOPE_Q8, {16'($urandom_range(0, 65535)), slope});
      csr_write(REG_DECIMAL_POSITION, 32'($urandom_range(0, 7)));
      settings_used++;
   endtask

   function automatic logic [15:0] random_sample();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r == 0) v = 0;
      else if (r == 1) v = 1023;
      else if (r < 5 || !realistic) v = $urandom_range(0, 1023);
      else begin
         v = int'(cfg_zo) + $urandom_range(0, 400) - 200;
         if (v < 0) v = 0;
         if (v > 1023) v = 1023;
      end
      return {6'($urandom_range(0, 63)), 10'(v)};
   endfunction

   function automatic plan_row_type plan_cfg(input logic [1:0] idx, input logic [31:0] value);
      return '{is_cfg: 1'b1, idx: idx, value: value, text: '0};
   endfunction

   function automatic plan_row_type plan_sample(input logic [15:0] data,
                                                input logic [39:0] text);
      return '{is_cfg: 1'b0, idx: REG_SAMPLE_COUNT, value: {16'd0, data}, text: text};
   endfunction

   initial begin
      logic [31:0]   rd;
      logic [7:0]    ch;
      plan_row_type  row;
      int            b;

      cfg_count = SAMPLE_COUNT_RESET;
      cfg_zo    = ZERO_OFFSET_RESET;
      cfg_slope = SLOPE_Q8_RESET;
      cfg_dp    = DECIMAL_POSITION_RESET;
      win_sum   = '0;
      win_taken = '0;

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      csr_read(REG_SAMPLE_COUNT, rd);
      if (rd[CNT_W-1:0] !== SAMPLE_COUNT_RESET) report_mismatch("sample_count reset", rd, 1000);
      csr_read(REG_ZERO_OFFSET, rd);
      if (rd[ZO_W-1:0] !== ZERO_OFFSET_RESET) report_mismatch("zero_offset reset", rd, 544);
      csr_read(REG_SLOPE_Q8, rd);
      if (rd[SLOPE_W-1:0] !== SLOPE_Q8_RESET) report_mismatch("slope_q8 reset", rd, 16'hFB00);
      csr_read(REG_DECIMAL_POSITION, rd);
      if (rd[DP_W-1:0] !== DECIMAL_POSITION_RESET) report_mismatch("decimal_position reset", rd, 3);

      plan.push_back(plan_cfg(REG_SAMPLE_COUNT, 32'd1));
      plan.push_back(plan_sample(16'd544, "000.0"));
      plan.push_back(plan_sample(16'd0, "000.0"));
      plan.push_back(plan_cfg(REG_SLOPE_Q8, 32'h7FFF));
      plan.push_back(plan_cfg(REG_ZERO_OFFSET, 32'd1023));
      plan.push_back(plan_sample(16'd0, "999.9"));
      plan.push_back(plan_sample(16'd1023, "000.0"));
      plan.push_back(plan_sample(16'hFC00, "999.9"));
      plan.push_back(plan_cfg(REG_SLOPE_Q8, 32'h8000));
      plan.push_back(plan_cfg(REG_ZERO_OFFSET, 32'd0));
      plan.push_back(plan_sample(16'd1023, "999.9"));
      plan.push_back(plan_sample(16'hFFFF, "999.9"));
      plan.push_back(plan_cfg(REG_DECIMAL_POSITION, 32'd4));
      plan.push_back(plan_sample(16'd1023, "9999"));
      plan.push_back(plan_cfg(REG_DECIMAL_POSITION, 32'd0));
      plan.push_back(plan_sample(16'd1023, ".9999"));
      plan.push_back(plan_cfg(REG_DECIMAL_POSITION, 32'd7));
      plan.push_back(plan_sample(16'd1023, "9999"));
      plan.push_back(plan_cfg(REG_SLOPE_Q8, 32'd256));
      plan.push_back(plan_cfg(REG_ZERO_OFFSET, 32'd1023));
      plan.push_back(plan_cfg(REG_DECIMAL_POSITION, 32'd1));
      plan.push_back(plan_sample(16'd1000, "0.023"));
      plan.push_back(plan_cfg(REG_SAMPLE_COUNT, 32'd0));
      plan.push_back(plan_sample(16'd1020, "0.003"));
      plan.push_back(plan_cfg(REG_SLOPE_Q8, 32'hFFFF));
      plan.push_back(plan_cfg(REG_ZERO_OFFSET, 32'd0));
      plan.push_back(plan_sample(16'd1023, "0.003"));
      plan.push_back(plan_cfg(REG_SLOPE_Q8, 32'd256));
      plan.push_back(plan_cfg(REG_ZERO_OFFSET, 32'd1023));
      plan.push_back(plan_cfg(REG_SAMPLE_COUNT, 32'd65535));
      plan.push_back(plan_sample(16'd100, 40'd0));
      plan.push_back(plan_sample(16'd200, 40'd0));
      plan.push_back(plan_sample(16'd300, 40'd0));
      plan.push_back(plan_sample(16'd400, 40'd0));
      plan.push_back(plan_sample(16'd500, 40'd0));
      plan.push_back(plan_cfg(REG_SAMPLE_COUNT, 32'd2));
      plan.push_back(plan_sample(16'd600, 40'd0));

      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_cfg) begin
            wait_drained();
            csr_write(row.idx, row.value);
            settings_used++;
         end else begin
            send_sample(row.value[15:0]);
            if (row.text != '0) begin
               // The typed characters replace all characters still in the queue.
               expected_chars.delete();
               for (b = 4; b >= 0; b--) begin
                  ch = row.text[8*b +: 8];
                  if (ch != 8'd0) expected_chars.push_back({(b == 0), ch});
               end
            end
         end
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         for (int set = 0; set < 3; set++) begin
            wait_drained();
            pick_setting();
            for (int k = 0; k < 36; k++) begin
               if (phase == 0 && set == 1 && k == 0) long_hold = 1'b1;
               send_sample(random_sample());
            end
         end
      end

      wait_drained();
      $display("Checked %0d readings (%0d characters) from %0d samples over %0d settings,",
               readings_due, chars_seen, samples_sent, settings_used);
      $display("with free-running, sender-idle, receiver-stall and mixed handshakes.");
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
